### rtl/efdp_pkg.sv
// Package for the encoder frame delta parser.
// Holds frame constants, status and phase codes, register indexes and the
// structs passed between the parser and the delta pipeline. No dependencies.
`timescale 1ns / 1ps

package efdp_pkg;

  localparam int DATA_W            = 32;
  localparam int CFG_W             = 31;
  localparam int COUNT_WIDTH_DEF   = 32;

  // Frame bytes
  localparam logic [7:0] START_BYTE = 8'hFF;
  localparam logic [7:0] ENC_LEN    = 8'h0D;
  localparam logic [7:0] ID_FIRST   = 8'h03;
  localparam logic [7:0] ID_SECOND  = 8'h05;
  localparam logic [7:0] ENC_BODY   = ENC_LEN - 8'd2;

  // Register indexes and reset values
  localparam logic CFG_WRAP_MODULUS = 1'b0;
  localparam logic CFG_JUMP_LIMIT   = 1'b1;
  localparam logic [CFG_W-1:0] WRAP_RESET = 31'd65536;
  localparam logic [CFG_W-1:0] JUMP_RESET = 31'd32768;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_START = 2'd1,
    ST_BAD_ID    = 2'd2,
    ST_SKIPPED   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_LENGTH = 2'd1,
    PH_BODY   = 2'd2
  } phase_t;

  // One parsed frame event: current and previous counts per wheel
  typedef struct packed {
    status_t             status;
    logic [DATA_W-1:0]   left_now;
    logic [DATA_W-1:0]   left_prev;
    logic [DATA_W-1:0]   right_now;
    logic [DATA_W-1:0]   right_prev;
  } evt_t;

  // One result item
  typedef struct packed {
    status_t             status;
    logic [DATA_W-1:0]   left_delta;
    logic [DATA_W-1:0]   right_delta;
    logic [DATA_W-1:0]   left_count;
    logic [DATA_W-1:0]   right_count;
  } res_t;

endpackage

### rtl/efdp_parser.sv
// Byte-level frame parser: start/length/body state machine, count shift
// registers and stored previous counts. Emits one registered event per frame or
// bad start byte. Depends on efdp_pkg.
`timescale 1ns / 1ps

module efdp_parser
  import efdp_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        adv,        // pipeline moves this cycle
  input  logic        take,       // byte transfer this cycle
  input  logic [7:0]  rx_byte,
  output logic        ev_valid,
  output evt_t        ev
);

  localparam int SHIFT = DATA_W - COUNT_WIDTH;

  // Body positions within an encoder frame
  localparam logic [7:0] POS_ID0   = 8'd0;
  localparam logic [7:0] POS_ID1   = 8'd1;
  localparam logic [7:0] POS_L_LO  = 8'd2;
  localparam logic [7:0] POS_L_HI  = 8'd5;
  localparam logic [7:0] POS_R_LO  = 8'd6;
  localparam logic [7:0] POS_R_HI  = 8'd9;

  phase_t             phase, phase_next;
  logic [7:0]         bytes_left, bytes_left_next;
  status_t            frame_kind, frame_kind_next;
  logic               identity_ok, identity_ok_next;
  logic [DATA_W-1:0]  left_shift, left_shift_next;
  logic [DATA_W-1:0]  right_shift, right_shift_next;
  logic [DATA_W-1:0]  left_prev, left_prev_next;
  logic [DATA_W-1:0]  right_prev, right_prev_next;
  logic               primed, primed_next;

  logic               emit;
  evt_t               ev_next;

  logic [7:0]         pos;
  logic [DATA_W-1:0]  left_now, right_now;
  logic               last_body;

  assign pos       = ENC_BODY - bytes_left;
  assign last_body = (bytes_left <= 8'd1);

  // Keep the low COUNT_WIDTH bits and sign-extend
  assign left_now  = DATA_W'($signed(left_shift << SHIFT) >>> SHIFT);
  assign right_now = DATA_W'($signed(right_shift << SHIFT) >>> SHIFT);

  // Next state
  always_comb begin
    phase_next       = phase;
    bytes_left_next  = bytes_left;
    frame_kind_next  = frame_kind;
    identity_ok_next = identity_ok;
    left_shift_next  = left_shift;
    right_shift_next = right_shift;
    left_prev_next   = left_prev;
    right_prev_next  = right_prev;
    primed_next      = primed;
    case (phase)
      PH_IDLE: begin
        if (rx_byte == START_BYTE) begin
          phase_next = PH_LENGTH;
        end
      end
      PH_LENGTH: begin
        if (rx_byte == ENC_LEN) begin
          frame_kind_next  = ST_OK;
          identity_ok_next = 1'b1;
          bytes_left_next  = ENC_BODY;
          phase_next       = PH_BODY;
        end else begin
          frame_kind_next  = ST_SKIPPED;
          identity_ok_next = 1'b0;
          if (rx_byte <= 8'd2) begin
            bytes_left_next = 8'd0;
            phase_next      = PH_IDLE;
          end else begin
            bytes_left_next = rx_byte - 8'd2;
            phase_next      = PH_BODY;
          end
        end
      end
      PH_BODY: begin
        if (frame_kind == ST_OK) begin
          if (pos == POS_ID0) begin
            if (rx_byte != ID_FIRST) identity_ok_next = 1'b0;
          end else if (pos == POS_ID1) begin
            if (rx_byte != ID_SECOND) identity_ok_next = 1'b0;
          end else if (pos >= POS_L_LO && pos <= POS_L_HI) begin
            left_shift_next = {left_shift[DATA_W-9:0], rx_byte};
          end else if (pos >= POS_R_LO && pos <= POS_R_HI) begin
            right_shift_next = {right_shift[DATA_W-9:0], rx_byte};
          end
        end
        if (!last_body) begin
          bytes_left_next = bytes_left - 8'd1;
        end else begin
          bytes_left_next = 8'd0;
          phase_next      = PH_IDLE;
          if (frame_kind == ST_OK && identity_ok) begin
            left_prev_next  = left_now;
            right_prev_next = right_now;
            primed_next     = 1'b1;
          end
        end
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase
  end

  // Event outputs; non-encoder results carry now == prev so the change is zero
  always_comb begin
    emit              = 1'b0;
    ev_next.status    = ST_OK;
    ev_next.left_now  = left_prev;
    ev_next.left_prev = left_prev;
    ev_next.right_now = right_prev;
    ev_next.right_prev = right_prev;
    case (phase)
      PH_IDLE: begin
        if (rx_byte != START_BYTE) begin
          emit           = 1'b1;
          ev_next.status = ST_BAD_START;
        end
      end
      PH_LENGTH: begin
        if (rx_byte != ENC_LEN && rx_byte <= 8'd2) begin
          emit           = 1'b1;
          ev_next.status = ST_SKIPPED;
        end
      end
      PH_BODY: begin
        if (last_body) begin
          emit = 1'b1;
          if (frame_kind != ST_OK) begin
            ev_next.status = ST_SKIPPED;
          end else if (!identity_ok) begin
            ev_next.status = ST_BAD_ID;
          end else begin
            ev_next.status     = ST_OK;
            ev_next.left_now   = left_now;
            ev_next.right_now  = right_now;
            ev_next.left_prev  = primed ? left_prev : left_now;
            ev_next.right_prev = primed ? right_prev : right_now;
          end
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  // Parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      bytes_left  <= 8'd0;
      frame_kind  <= ST_OK;
      identity_ok <= 1'b0;
      left_shift  <= '0;
      right_shift <= '0;
      left_prev   <= '0;
      right_prev  <= '0;
      primed      <= 1'b0;
    end else if (take) begin
      phase       <= phase_next;
      bytes_left  <= bytes_left_next;
      frame_kind  <= frame_kind_next;
      identity_ok <= identity_ok_next;
      left_shift  <= left_shift_next;
      right_shift <= right_shift_next;
      left_prev   <= left_prev_next;
      right_prev  <= right_prev_next;
      primed      <= primed_next;
    end
  end

  // Event register
  always_ff @(posedge clk) begin
    if (rst) begin
      ev_valid <= 1'b0;
    end else if (adv) begin
      ev_valid <= take && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ev <= ev_next;
    end
  end

endmodule

### rtl/efdp_delta.sv
// Delta pipeline: difference, wrap test, wrap correction and negation of the
// right change, ending in the result register. Depends on efdp_pkg.
`timescale 1ns / 1ps

module efdp_delta
  import efdp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  logic              ev_valid,
  input  evt_t              ev,
  input  logic [CFG_W-1:0]  wrap_modulus,
  input  logic [CFG_W-1:0]  jump_limit,
  output logic              res_valid,
  output res_t              res
);

  logic [DATA_W-1:0] modulus, limit;
  assign modulus = {1'b0, wrap_modulus};
  assign limit   = {1'b0, jump_limit};

  // Stage 2: raw changes
  logic              s2_valid;
  status_t           s2_status;
  logic [DATA_W-1:0] s2_dl, s2_dr, s2_lc, s2_rc;

  // Stage 3: wrap decision, right change pre-negated
  logic              s3_valid;
  status_t           s3_status;
  logic [DATA_W-1:0] s3_dl, s3_ndr, s3_lc, s3_rc;
  logic              s3_l_add, s3_l_sub, s3_r_add, s3_r_sub;

  // A negative change exceeds the limit when ~d >= limit; a positive one when d > limit
  function automatic logic wrap_add(input logic [DATA_W-1:0] d, input logic [DATA_W-1:0] lim);
    wrap_add = d[DATA_W-1] && (~d >= lim);
  endfunction

  function automatic logic wrap_sub(input logic [DATA_W-1:0] d, input logic [DATA_W-1:0] lim);
    wrap_sub = !d[DATA_W-1] && (d > lim);
  endfunction

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      res_valid <= 1'b0;
    end else if (adv) begin
      s2_valid  <= ev_valid;
      s3_valid  <= s2_valid;
      res_valid <= s3_valid;
    end
  end

  // Payload stages
  always_ff @(posedge clk) begin
    if (adv) begin
      s2_status <= ev.status;
      s2_dl     <= ev.left_now - ev.left_prev;
      s2_dr     <= ev.right_now - ev.right_prev;
      s2_lc     <= ev.left_now;
      s2_rc     <= ev.right_now;

      s3_status <= s2_status;
      s3_dl     <= s2_dl;
      s3_ndr    <= DATA_W'(0) - s2_dr;
      s3_lc     <= s2_lc;
      s3_rc     <= s2_rc;
      s3_l_add  <= wrap_add(s2_dl, limit);
      s3_l_sub  <= wrap_sub(s2_dl, limit);
      s3_r_add  <= wrap_add(s2_dr, limit);
      s3_r_sub  <= wrap_sub(s2_dr, limit);

      res.status      <= s3_status;
      res.left_delta  <= s3_l_add ? s3_dl + modulus :
                         s3_l_sub ? s3_dl - modulus : s3_dl;
      // -(d + m) = -d - m and -(d - m) = -d + m
      res.right_delta <= s3_r_add ? s3_ndr - modulus :
                         s3_r_sub ? s3_ndr + modulus : s3_ndr;
      res.left_count  <= s3_lc;
      res.right_count <= s3_rc;
    end
  end

endmodule

### rtl/encoder_frame_delta_parser.sv
// Encoder frame delta parser: top level with configuration registers, stream
// handshake and the two stages below. Depends on efdp_pkg, efdp_parser,
// efdp_delta.
`timescale 1ns / 1ps

// Takes one received byte per transfer on s_* and finds frames of the form
// 0xFF, length, body. A 13-byte frame with identity 03 05 carries big-endian
// left and right encoder counts; its last byte yields one result with the
// wrap-corrected left change and negated right change since the last good
// frame (zero for the first). Bad start bytes, bad identities and skipped
// frames yield status-only results; other bytes yield nothing. A byte is
// taken every cycle while the result register is empty or being taken;
// a result passes the four parse/difference/wrap-test/correction registers.
// Configuration writes take effect at once and belong only in idle time.

module encoder_frame_delta_parser
  import efdp_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  // Input stream; tdata: rx_byte[7:0]
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [7:0]        s_tdata,
  // Result stream; tdata: status[1:0], left_delta[33:2], right_delta[65:34],
  // left_count[97:66], right_count[129:98], zero[135:130]
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [135:0]      m_tdata,
  // Configuration write port
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [CFG_W-1:0]  cfg_data
);

  logic [CFG_W-1:0] wrap_modulus, jump_limit;
  logic             adv, take;
  logic             ev_valid;
  evt_t             ev;
  res_t             res;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      wrap_modulus <= WRAP_RESET;
      jump_limit   <= JUMP_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WRAP_MODULUS: wrap_modulus <= cfg_data;
        CFG_JUMP_LIMIT:   jump_limit   <= cfg_data;
        default:          wrap_modulus <= wrap_modulus;
      endcase
    end
  end

  // Whole pipeline moves when the result register is free
  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;
  assign take     = s_tvalid && adv;

  efdp_parser #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_parser (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .take     (take),
    .rx_byte  (s_tdata),
    .ev_valid (ev_valid),
    .ev       (ev)
  );

  efdp_delta u_delta (
    .clk          (clk),
    .rst          (rst),
    .adv          (adv),
    .ev_valid     (ev_valid),
    .ev           (ev),
    .wrap_modulus (wrap_modulus),
    .jump_limit   (jump_limit),
    .res_valid    (m_tvalid),
    .res          (res)
  );

  assign m_tdata = {6'd0, res.right_count, res.left_count, res.right_delta,
                    res.left_delta, res.status};

  // Status-only results carry zero changes
  a_zero_delta: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[1:0] != ST_OK) |-> (m_tdata[65:2] == 64'd0))
    else $error("nonzero change on a status-only result");

  // Input is held off only while a result waits
  a_stall: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (m_tvalid && !m_tready))
    else $error("input stalled without a pending result");

  // A held result does not change
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("pending result changed");

endmodule

### bench/efdp_delta_checker.sv
// Checker for the encoder frame delta parser: watches the byte, result and
// configuration channels, predicts each result and compares it field by field.
// Depends on efdp_pkg.
`timescale 1ns / 1ps

module efdp_delta_checker
  import efdp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  input  logic              s_tready,
  input  logic [7:0]        s_tdata,
  input  logic              m_tvalid,
  input  logic              m_tready,
  input  logic [135:0]      m_tdata,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [CFG_W-1:0]  cfg_data,
  output int                fail_count,
  output int                outstanding
);

  localparam int MAX_REPORTS = 60;

  // Results predicted but not yet seen on the result stream
  res_t frame_results_due[$];

  // Configuration copy
  logic [CFG_W-1:0] wrap_mod;
  logic [CFG_W-1:0] jump_lim;

  // Parser state copy
  phase_t           phase;
  logic [7:0]       body_left;
  status_t          kind;
  logic             id_good;
  logic [31:0]      left_acc;
  logic [31:0]      right_acc;
  logic [31:0]      left_last;
  logic [31:0]      right_last;
  logic             primed;

  int fails = 0;
  int reports = 0;

  // Keep the low COUNT_WIDTH bits of a received count, sign-extended
  function automatic logic [31:0] sext_count(input logic [31:0] raw);
    logic [31:0] v;
    v = raw;
    for (int i = COUNT_WIDTH_DEF; i < 32; i++) v[i] = raw[COUNT_WIDTH_DEF-1];
    return v;
  endfunction

  // Count change, pulled toward zero by the modulus when past the jump limit
  function automatic logic [31:0] wrap_fix(input logic [31:0] now, input logic [31:0] was);
    logic [31:0] d;
    logic [31:0] mag;
    d   = now - was;
    mag = d[31] ? (32'd0 - d) : d;
    if (mag > {1'b0, jump_lim}) begin
      if (d[31]) d = d + {1'b0, wrap_mod};
      else if (d != 32'd0) d = d - {1'b0, wrap_mod};
    end
    return d;
  endfunction

  // Advance the parser copy by one byte; queue a result when one is due
  task automatic parse_rx_byte(input logic [7:0] b);
    res_t        r;
    logic        done;
    logic [7:0]  pos;
    logic [31:0] lnow;
    logic [31:0] rnow;
    r    = '0;
    done = 1'b0;
    case (phase)
      PH_IDLE: begin
        if (b == START_BYTE) begin
          phase = PH_LENGTH;
        end else begin
          r.status = ST_BAD_START;
          done     = 1'b1;
        end
      end
      PH_LENGTH: begin
        if (b == ENC_LEN) begin
          kind      = ST_OK;
          id_good   = 1'b1;
          body_left = ENC_BODY;
          phase     = PH_BODY;
        end else begin
          kind    = ST_SKIPPED;
          id_good = 1'b0;
          if (b <= 8'd2) begin
            // nothing to skip: report with the length byte
            body_left = 8'd0;
            phase     = PH_IDLE;
            r.status  = ST_SKIPPED;
            done      = 1'b1;
          end else begin
            body_left = b - 8'd2;
            phase     = PH_BODY;
          end
        end
      end
      default: begin
        if (kind == ST_OK) begin
          pos = ENC_BODY - body_left;
          if (pos == 8'd0 && b != ID_FIRST) id_good = 1'b0;
          else if (pos == 8'd1 && b != ID_SECOND) id_good = 1'b0;
          else if (pos >= 8'd2 && pos <= 8'd5) left_acc = {left_acc[23:0], b};
          else if (pos >= 8'd6 && pos <= 8'd9) right_acc = {right_acc[23:0], b};
        end
        if (body_left > 8'd1) begin
          body_left = body_left - 8'd1;
        end else begin
          body_left = 8'd0;
          phase     = PH_IDLE;
          done      = 1'b1;
          if (kind != ST_OK) begin
            r.status = ST_SKIPPED;
          end else if (!id_good) begin
            r.status = ST_BAD_ID;
          end else begin
            lnow = sext_count(left_acc);
            rnow = sext_count(right_acc);
            // first good frame only primes the stored counts
            if (!primed) begin
              left_last  = lnow;
              right_last = rnow;
              primed     = 1'b1;
            end
            r.status      = ST_OK;
            r.left_delta  = wrap_fix(lnow, left_last);
            r.right_delta = 32'd0 - wrap_fix(rnow, right_last);
            left_last     = lnow;
            right_last    = rnow;
          end
        end
      end
    endcase
    if (done) begin
      r.left_count  = left_last;
      r.right_count = right_last;
      frame_results_due.push_back(r);
    end
  endtask

  task automatic check_field(input string what, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      fails++;
      if (reports < MAX_REPORTS)
        $display("%0t: %s mismatch: expected %h, actual %h", $time, what, want, got);
      reports++;
    end
  endtask

  task automatic check_result(input logic [135:0] d);
    res_t want;
    if (frame_results_due.size() == 0) begin
      fails++;
      if (reports < MAX_REPORTS)
        $display("%0t: result with none expected: expected nothing, actual %h", $time, d);
      reports++;
      return;
    end
    want = frame_results_due.pop_front();
    check_field("status", {30'd0, want.status}, {30'd0, d[1:0]});
    check_field("left_delta", want.left_delta, d[33:2]);
    check_field("right_delta", want.right_delta, d[65:34]);
    check_field("left_count", want.left_count, d[97:66]);
    check_field("right_count", want.right_count, d[129:98]);
    check_field("zero fill", 32'd0, {26'd0, d[135:130]});
  endtask

  // Sample every channel at the clock edge
  always @(posedge clk) begin
    if (rst) begin
      wrap_mod   = WRAP_RESET;
      jump_lim   = JUMP_RESET;
      phase      = PH_IDLE;
      body_left  = 8'd0;
      kind       = ST_OK;
      id_good    = 1'b0;
      left_acc   = 32'd0;
      right_acc  = 32'd0;
      left_last  = 32'd0;
      right_last = 32'd0;
      primed     = 1'b0;
      frame_results_due.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_WRAP_MODULUS) wrap_mod = cfg_data;
        else jump_lim = cfg_data;
      end
      if (m_tvalid && m_tready) check_result(m_tdata);
      if (s_tvalid && s_tready) parse_rx_byte(s_tdata);
    end
    fail_count  <= fails;
    outstanding <= frame_results_due.size();
  end

endmodule

### bench/encoder_frame_delta_parser_tb.sv
// Top of the encoder frame delta parser testbench: clock, reset, byte and
// frame stimulus, receiver stalls, configuration phases and the verdict.
// Depends on efdp_pkg, encoder_frame_delta_parser and efdp_delta_checker.
`timescale 1ns / 1ps

module encoder_frame_delta_parser_tb;
  import efdp_pkg::*;

  localparam int STALL_LIMIT   = 4000;
  localparam int DRAIN_CYCLES  = 12;
  localparam int PHASE_BYTES   = 120;
  localparam int N_PHASES      = 7;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [7:0]        s_tdata = 8'd0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [135:0]      m_tdata;
  logic              cfg_we = 1'b0;
  logic              cfg_index = CFG_WRAP_MODULUS;
  logic [CFG_W-1:0]  cfg_data = '0;

  int fail_count;
  int outstanding;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int quiet_cycles = 0;
  int bytes_sent = 0;

  // Settings in force, used to aim the count changes at the wrap boundary
  logic [CFG_W-1:0] cur_wrap = WRAP_RESET;
  logic [CFG_W-1:0] cur_jump = JUMP_RESET;
  logic [31:0]      sent_left = 32'd0;
  logic [31:0]      sent_right = 32'd0;

  // Register settings per phase; the last one is drawn at random
  logic [CFG_W-1:0] wrap_plan [0:N_PHASES-1] =
    '{31'd65536, 31'd1, 31'h7FFF_FFFE, 31'd256, 31'd0, 31'h7FFF_FFFF, 31'd65536};
  logic [CFG_W-1:0] jump_plan [0:N_PHASES-1] =
    '{31'd32768, 31'd0, 31'h7FFF_FFFE, 31'd127, 31'd1000, 31'h7FFF_FFFF, 31'd32768};

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  encoder_frame_delta_parser DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  efdp_delta_checker u_delta_checker (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  // Receiver stalls
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog on cycles with no transfer at all
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("encoder_frame_delta_parser_tb: FAIL");
      $finish;
    end
  end

  // One byte transfer, after a random idle gap
  task automatic push_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_encoder_frame(input logic [7:0] id0, input logic [7:0] id1,
                                    input logic [31:0] lcount, input logic [31:0] rcount);
    push_byte(START_BYTE);
    push_byte(ENC_LEN);
    push_byte(id0);
    push_byte(id1);
    for (int i = 3; i >= 0; i--) push_byte(lcount[8*i +: 8]);
    for (int i = 3; i >= 0; i--) push_byte(rcount[8*i +: 8]);
    push_byte(8'($urandom));
  endtask

  // Wait for every result, then let the pipeline empty
  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  // Next count of a wheel: small steps, steps around the wrap, limit edges
  function automatic logic [31:0] next_count(input logic [31:0] prior);
    logic [31:0] lim;
    logic [31:0] step;
    logic        down;
    lim  = (cur_jump > 31'd1000) ? 32'd1000 : {1'b0, cur_jump};
    down = 1'($urandom_range(1));
    case ($urandom_range(5))
      0: step = 32'd0;
      1: step = $urandom_range(lim);
      2: step = {1'b0, cur_wrap} - $urandom_range(lim);
      3: step = 32'h8000_0000;
      4: step = {1'b0, cur_jump} + $urandom_range(1);
      default: step = $urandom;
    endcase
    return down ? prior - step : prior + step;
  endfunction

  // Mostly good encoder frames, with broken frames and line noise mixed in
  task automatic random_frame();
    int          pick;
    logic [31:0] l;
    logic [31:0] r;
    logic [7:0]  id0;
    logic [7:0]  id1;
    logic [7:0]  len;
    pick = $urandom_range(99);
    if (pick < 60) begin
      l = next_count(sent_left);
      r = next_count(sent_right);
      send_encoder_frame(ID_FIRST, ID_SECOND, l, r);
      sent_left  = l;
      sent_right = r;
    end else if (pick < 70) begin
      id0 = ID_FIRST;
      id1 = ID_SECOND;
      case ($urandom_range(2))
        0: begin
          id0 = 8'($urandom);
          if (id0 == ID_FIRST) id0 = ~ID_FIRST;
        end
        1: begin
          id1 = 8'($urandom);
          if (id1 == ID_SECOND) id1 = ~ID_SECOND;
        end
        default: begin
          id0 = ID_SECOND;
          id1 = ID_FIRST;
        end
      endcase
      send_encoder_frame(id0, id1, $urandom, $urandom);
    end else if (pick < 82) begin
      // other length, now and then a long one
      len = ($urandom_range(19) == 0) ? 8'($urandom) : 8'($urandom_range(40));
      if (len == ENC_LEN) len = ENC_LEN - 8'd1;
      push_byte(START_BYTE);
      push_byte(len);
      for (int i = 2; i < len; i++) push_byte(8'($urandom));
    end else if (pick < 92) begin
      repeat ($urandom_range(3, 1)) push_byte(8'($urandom));
    end else begin
      // encoder frame cut short; what follows lands in its body
      push_byte(START_BYTE);
      push_byte(ENC_LEN);
      repeat ($urandom_range(10, 1)) push_byte(8'($urandom));
    end
  endtask

  initial begin
    int start_count;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: bad start bytes, short lengths, priming frame at the extremes
    push_byte(8'h00);
    push_byte(8'hFE);
    push_byte(START_BYTE);
    push_byte(8'h00);
    push_byte(START_BYTE);
    push_byte(8'h02);
    push_byte(START_BYTE);
    push_byte(8'h03);
    push_byte(8'hAA);
    send_encoder_frame(ID_FIRST, ID_SECOND, 32'h7FFF_FFFF, 32'h8000_0000);
    sent_left  = 32'h7FFF_FFFF;
    sent_right = 32'h8000_0000;

    // Random phases, each with its own settings and idle pattern
    for (int p = 0; p < N_PHASES; p++) begin
      settle();
      if (p == N_PHASES - 1) begin
        wrap_plan[p] = CFG_W'($urandom_range(32'h7FFF_FFFE, 1));
        jump_plan[p] = CFG_W'($urandom_range(32'h7FFF_FFFE, 0));
      end
      cur_wrap = wrap_plan[p];
      cur_jump = jump_plan[p];
      write_reg(CFG_WRAP_MODULUS, cur_wrap);
      write_reg(CFG_JUMP_LIMIT, cur_jump);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 53; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 53; end
        default: begin send_idle_pct = 13; recv_stall_pct = 13; end
      endcase
      start_count = bytes_sent;
      while (bytes_sent - start_count < PHASE_BYTES) random_frame();
    end

    settle();
    if (fail_count == 0)
      $display("encoder_frame_delta_parser_tb: PASS");
    else
      $display("encoder_frame_delta_parser_tb: FAIL");
    $finish;
  end

endmodule
